/* design/layer_norm_forward_backward_unit_assert.svh */
// Assertion macros shared by the layer norm modules.
// Each macro expects clk and rst in scope at the point of use.
`ifndef LAYER_NORM_FORWARD_BACKWARD_UNIT_ASSERT_SVH
`define LAYER_NORM_FORWARD_BACKWARD_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LNFB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LNFB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lnfb_pkg.sv */
package lnfb_pkg;

  // Default sizing of the feature vector and fixed-point format.
  localparam int MAX_FEATURES_DEF = 64;
  localparam int FRAC_BITS_DEF    = 16;

  // Fixed widths of the data path.
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int PROD_W = 96;
  localparam int EPS_W  = 31;
  localparam int STEP_W = 7;

  // Magnitude cap used by the shifted products.
  localparam logic [ACC_W-1:0] MAG_CAP = 64'h4000_0000_0000_0000;

  // Iteration counts of the shared arithmetic unit.
  localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd32;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd64;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd32;
  localparam logic [ACC_W-1:0]  SQRT_BIT0  = 64'h4000_0000_0000_0000;

  // Item kinds, shared by the action input and the result kind output.
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } lnfb_op_t;

  typedef struct packed {
    logic              start;
    lnfb_op_t          op;
    logic [ACC_W-1:0]  a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_RD,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_SQRT_WAIT,
    ST_INV_WAIT,
    ST_X_RD,
    ST_X_GO,
    ST_X_WAIT,
    ST_B1_RD,
    ST_B1_GO,
    ST_B1_WAIT,
    ST_B2_RD,
    ST_B2_GO,
    ST_B2_WAIT,
    ST_B2_DIV,
    ST_B2_SC,
    ST_PUT,
    ST_EMIT
  } lnfb_state_t;

  // Magnitude of a signed 32-bit word.
  function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (32'd0 - x) : x;
  endfunction

  // Magnitude of a signed 64-bit word.
  function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] x);
    return x[ACC_W-1] ? (64'd0 - x) : x;
  endfunction

  // Apply a sign to a magnitude and saturate to 32 bits.
  function automatic logic [DATA_W-1:0] sat32(input logic neg,
                                              input logic [ACC_W-1:0] mag);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[DATA_W-1:0]);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/lnfb_ram.sv */
module lnfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/lnfb_alu.sv */
`include "layer_norm_forward_backward_unit_assert.svh"

module lnfb_alu (
  input  logic               clk,
  input  logic               rst,
  input  lnfb_pkg::alu_req_t req,
  output lnfb_pkg::alu_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  lnfb_pkg::lnfb_op_t             op_q;
  logic [lnfb_pkg::STEP_W-1:0]    cnt;
  logic [lnfb_pkg::PROD_W-1:0]    acc;
  logic [lnfb_pkg::PROD_W-1:0]    sh;
  logic [lnfb_pkg::ACC_W-1:0]     mq;
  logic [lnfb_pkg::DATA_W-1:0]    rem;
  logic [lnfb_pkg::DATA_W-1:0]    dvs;

  logic [lnfb_pkg::PROD_W-1:0]    mul_sum;
  logic [lnfb_pkg::DATA_W:0]      trial;
  logic [lnfb_pkg::DATA_W:0]      trial_sub;
  logic                           div_fit;
  logic [lnfb_pkg::DATA_W-1:0]    rem_next;
  logic [lnfb_pkg::ACC_W-1:0]     sq_t;
  logic                           sq_fit;

  // One step of each operation: shift-add multiply, restoring divide,
  // and the digit-by-digit square root.
  always_comb begin
    mul_sum   = acc + sh;
    trial     = {rem, mq[lnfb_pkg::ACC_W-1]};
    trial_sub = trial - {1'b0, dvs};
    div_fit   = (trial >= {1'b0, dvs});
    rem_next  = div_fit ? trial_sub[lnfb_pkg::DATA_W-1:0] : trial[lnfb_pkg::DATA_W-1:0];
    sq_t      = sh[lnfb_pkg::ACC_W-1:0] + mq;
    sq_fit    = (acc[lnfb_pkg::ACC_W-1:0] >= sq_t);
  end

  // Control and operand registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_q <= req.op;
        unique case (req.op)
          lnfb_pkg::OP_MUL: begin
            acc <= '0;
            sh  <= {32'd0, req.a};
            mq  <= {32'd0, req.b};
            cnt <= lnfb_pkg::MUL_STEPS;
          end
          lnfb_pkg::OP_DIV: begin
            rem <= '0;
            mq  <= req.a;
            dvs <= req.b;
            cnt <= lnfb_pkg::DIV_STEPS;
          end
          lnfb_pkg::OP_SQRT: begin
            acc <= {32'd0, req.a};
            sh  <= '0;
            mq  <= lnfb_pkg::SQRT_BIT0;
            cnt <= lnfb_pkg::SQRT_STEPS;
          end
          default: begin
            cnt <= lnfb_pkg::MUL_STEPS;
          end
        endcase
      end else if (busy) begin
        unique case (op_q)
          lnfb_pkg::OP_MUL: begin
            if (mq[0]) begin
              acc <= mul_sum;
            end
            sh <= sh << 1;
            mq <= mq >> 1;
          end
          lnfb_pkg::OP_DIV: begin
            rem <= rem_next;
            mq  <= {mq[lnfb_pkg::ACC_W-2:0], div_fit};
          end
          lnfb_pkg::OP_SQRT: begin
            if (sq_fit) begin
              acc[lnfb_pkg::ACC_W-1:0] <= acc[lnfb_pkg::ACC_W-1:0] - sq_t;
              sh[lnfb_pkg::ACC_W-1:0]  <= (sh[lnfb_pkg::ACC_W-1:0] >> 1) + mq;
            end else begin
              sh[lnfb_pkg::ACC_W-1:0]  <= sh[lnfb_pkg::ACC_W-1:0] >> 1;
            end
            mq <= mq >> 2;
          end
          default: begin
            mq <= mq;
          end
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Result selection by the running operation.
  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    unique case (op_q)
      lnfb_pkg::OP_MUL:  rsp.res = acc;
      lnfb_pkg::OP_DIV:  rsp.res = {32'd0, mq};
      lnfb_pkg::OP_SQRT: rsp.res = {32'd0, sh[lnfb_pkg::ACC_W-1:0]};
      default:           rsp.res = acc;
    endcase
  end

  `LNFB_ASSERT_IMP(alu_start_when_free, req.start, !busy, "alu started while busy")
  `LNFB_ASSERT_NXT(alu_start_runs, req.start, busy, "alu did not begin after start")
  `LNFB_ASSERT_NXT(alu_done_pulse, done, !done, "alu done held for more than one cycle")

endmodule

/* design/layer_norm_forward_backward_unit.sv */
// Loading: one item per cycle while idle; input waits while a run is processed.
// Forward run after the last item: sum, mean, variance, root and inverse root,
// then a divide per result; backward run: a product pass, then per result a
// multiply, a divide and a scaling multiply, all on the shared multiply/divide/root unit.
// Reset (synchronous, rst high) clears counts, flags and inverse root, sets
// epsilon to 1; the sample and error stores are not cleared.
`include "layer_norm_forward_backward_unit_assert.svh"

module layer_norm_forward_backward_unit #(
  parameter int MAX_FEATURES = lnfb_pkg::MAX_FEATURES_DEF,
  parameter int FRAC_BITS    = lnfb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lnfb_pkg::EPS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic signed [lnfb_pkg::DATA_W-1:0] value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [lnfb_pkg::DATA_W-1:0] result_value,
  output logic                          result_kind,
  output logic                          result_last,
  output logic                          truncated
);

  localparam int ADDR_W = $clog2(MAX_FEATURES);
  localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FEATURES);
  localparam logic [63:0] VAR_CAP = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
  localparam logic [63:0] ONE_2F  = 64'd1 << (2 * FRAC_BITS);

  lnfb_pkg::lnfb_state_t state, state_next;

  logic [CNT_W-1:0]  element_count;
  logic [CNT_W-1:0]  fwd_len;
  logic              overflow_flag;
  logic [30:0]       epsilon;
  logic [31:0]       inverse_std;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  run_len;
  logic              run_kind;
  logic [63:0]       sum;
  logic [63:0]       acc2;
  logic [31:0]       mean;
  logic [31:0]       sd;
  logic [31:0]       dy;
  logic              neg;
  logic              pneg;
  logic [63:0]       quo;

  lnfb_pkg::alu_req_t alu_req;
  lnfb_pkg::alu_rsp_t alu_rsp;

  logic              s_we;
  logic [ADDR_W-1:0] s_waddr;
  logic [31:0]       s_wdata;
  logic [31:0]       s_rdata;
  logic              e_we;
  logic [31:0]       e_rdata;

  logic              in_fire;
  logic              out_fire;
  logic              has_room;
  logic              idx_last;
  logic [95:0]       prod_sh;
  logic [63:0]       prod_cap;
  logic [63:0]       quot;
  logic [32:0]       dev;
  logic [31:0]       dev_mag;
  logic [63:0]       var_sum;
  logic [63:0]       var_c;
  logic [31:0]       inv_sat;
  logic [31:0]       mean_q;
  logic [63:0]       sp;
  logic [CNT_W+32:0] ndy;
  logic [63:0]       term;
  logic [31:0]       sat_val;

  // Storage for samples (later the normalized values) and error values.
  lnfb_ram #(.WIDTH(lnfb_pkg::DATA_W), .DEPTH(MAX_FEATURES)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (idx),
    .rdata (s_rdata)
  );

  lnfb_ram #(.WIDTH(lnfb_pkg::DATA_W), .DEPTH(MAX_FEATURES)) u_error_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (element_count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (idx),
    .rdata (e_rdata)
  );

  // Shared multiply, divide and square root unit.
  lnfb_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Data path values derived from the unit result and the stores.
  always_comb begin
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    has_room = (element_count < MAX_CNT);
    idx_last = ((CNT_W'(idx) + CNT_W'(1)) == run_len);
    prod_sh  = alu_rsp.res >> FRAC_BITS;
    prod_cap = (prod_sh > {32'd0, lnfb_pkg::MAG_CAP}) ? lnfb_pkg::MAG_CAP : prod_sh[63:0];
    quot     = alu_rsp.res[63:0];
    dev      = {s_rdata[31], s_rdata} - {mean[31], mean};
    dev_mag  = dev[32] ? (32'd0 - dev[31:0]) : dev[31:0];
    var_sum  = quot + {33'd0, epsilon};
    var_c    = (var_sum > VAR_CAP) ? VAR_CAP : var_sum;
    inv_sat  = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    mean_q   = sum[63] ? (32'd0 - quot[31:0]) : quot[31:0];
    sp       = pneg ? (64'd0 - prod_cap) : prod_cap;
    ndy      = $signed({1'b0, run_len}) * $signed(dy);
    term     = {{(64 - CNT_W - 33){ndy[CNT_W+32]}}, ndy} - sum - sp;
    sat_val  = lnfb_pkg::sat32(neg, quo);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lnfb_pkg::ST_IDLE: begin
        if (in_fire && last) begin
          if (action == lnfb_pkg::KIND_FWD) begin
            state_next = lnfb_pkg::ST_SUM_RD;
          end else if (fwd_len != '0) begin
            state_next = lnfb_pkg::ST_B1_RD;
          end
        end
      end
      lnfb_pkg::ST_SUM_RD:  state_next = lnfb_pkg::ST_SUM_ACC;
      lnfb_pkg::ST_SUM_ACC: state_next = idx_last ? lnfb_pkg::ST_MEAN_GO : lnfb_pkg::ST_SUM_RD;
      lnfb_pkg::ST_MEAN_GO: state_next = lnfb_pkg::ST_MEAN_WAIT;
      lnfb_pkg::ST_MEAN_WAIT: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_VAR_RD;
      end
      lnfb_pkg::ST_VAR_RD: state_next = lnfb_pkg::ST_VAR_GO;
      lnfb_pkg::ST_VAR_GO: state_next = lnfb_pkg::ST_VAR_WAIT;
      lnfb_pkg::ST_VAR_WAIT: begin
        if (alu_rsp.done) begin
          state_next = idx_last ? lnfb_pkg::ST_VDIV_GO : lnfb_pkg::ST_VAR_RD;
        end
      end
      lnfb_pkg::ST_VDIV_GO: state_next = lnfb_pkg::ST_VDIV_WAIT;
      lnfb_pkg::ST_VDIV_WAIT: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_SQRT_WAIT;
      end
      lnfb_pkg::ST_SQRT_WAIT: begin
        if (alu_rsp.done) begin
          state_next = (quot == '0) ? lnfb_pkg::ST_X_RD : lnfb_pkg::ST_INV_WAIT;
        end
      end
      lnfb_pkg::ST_INV_WAIT: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_X_RD;
      end
      lnfb_pkg::ST_X_RD: state_next = lnfb_pkg::ST_X_GO;
      lnfb_pkg::ST_X_GO: state_next = (sd == '0) ? lnfb_pkg::ST_PUT : lnfb_pkg::ST_X_WAIT;
      lnfb_pkg::ST_X_WAIT: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_PUT;
      end
      lnfb_pkg::ST_B1_RD: state_next = lnfb_pkg::ST_B1_GO;
      lnfb_pkg::ST_B1_GO: state_next = lnfb_pkg::ST_B1_WAIT;
      lnfb_pkg::ST_B1_WAIT: begin
        if (alu_rsp.done) begin
          state_next = idx_last ? lnfb_pkg::ST_B2_RD : lnfb_pkg::ST_B1_RD;
        end
      end
      lnfb_pkg::ST_B2_RD: state_next = lnfb_pkg::ST_B2_GO;
      lnfb_pkg::ST_B2_GO: state_next = lnfb_pkg::ST_B2_WAIT;
      lnfb_pkg::ST_B2_WAIT: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_B2_DIV;
      end
      lnfb_pkg::ST_B2_DIV: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_B2_SC;
      end
      lnfb_pkg::ST_B2_SC: begin
        if (alu_rsp.done) state_next = lnfb_pkg::ST_PUT;
      end
      lnfb_pkg::ST_PUT: state_next = lnfb_pkg::ST_EMIT;
      lnfb_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (idx_last) begin
            state_next = lnfb_pkg::ST_IDLE;
          end else if (run_kind == lnfb_pkg::KIND_FWD) begin
            state_next = lnfb_pkg::ST_X_RD;
          end else begin
            state_next = lnfb_pkg::ST_B2_RD;
          end
        end
      end
      default: state_next = lnfb_pkg::ST_IDLE;
    endcase
  end

  // Handshakes, store writes and unit requests.
  always_comb begin
    in_ready    = (state == lnfb_pkg::ST_IDLE);
    out_valid   = (state == lnfb_pkg::ST_EMIT);
    cfg_ready   = 1'b1;
    s_we        = 1'b0;
    s_waddr     = element_count[ADDR_W-1:0];
    s_wdata     = value;
    e_we        = 1'b0;
    alu_req     = '0;
    alu_req.op  = lnfb_pkg::OP_MUL;
    unique case (state)
      lnfb_pkg::ST_IDLE: begin
        s_we = in_fire && has_room && (action == lnfb_pkg::KIND_FWD);
        e_we = in_fire && has_room && (action == lnfb_pkg::KIND_BWD);
      end
      lnfb_pkg::ST_MEAN_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = lnfb_pkg::OP_DIV;
        alu_req.a     = lnfb_pkg::abs64(sum);
        alu_req.b     = 32'(run_len);
      end
      lnfb_pkg::ST_VAR_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = lnfb_pkg::OP_MUL;
        alu_req.a     = {32'd0, dev_mag};
        alu_req.b     = dev_mag;
      end
      lnfb_pkg::ST_VDIV_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = lnfb_pkg::OP_DIV;
        alu_req.a     = acc2;
        alu_req.b     = 32'(run_len);
      end
      lnfb_pkg::ST_VDIV_WAIT: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = lnfb_pkg::OP_SQRT;
        alu_req.a     = var_c << FRAC_BITS;
      end
      lnfb_pkg::ST_SQRT_WAIT: begin
        alu_req.start = alu_rsp.done && (quot != '0);
        alu_req.op    = lnfb_pkg::OP_DIV;
        alu_req.a     = ONE_2F;
        alu_req.b     = quot[31:0];
      end
      lnfb_pkg::ST_X_GO: begin
        alu_req.start = (sd != '0);
        alu_req.op    = lnfb_pkg::OP_DIV;
        alu_req.a     = {32'd0, dev_mag} << FRAC_BITS;
        alu_req.b     = sd;
      end
      lnfb_pkg::ST_B1_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = lnfb_pkg::OP_MUL;
        alu_req.a     = {32'd0, lnfb_pkg::abs32(e_rdata)};
        alu_req.b     = lnfb_pkg::abs32(s_rdata);
      end
      lnfb_pkg::ST_B2_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = lnfb_pkg::OP_MUL;
        alu_req.a     = lnfb_pkg::abs64(acc2);
        alu_req.b     = lnfb_pkg::abs32(s_rdata);
      end
      lnfb_pkg::ST_B2_WAIT: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = lnfb_pkg::OP_DIV;
        alu_req.a     = lnfb_pkg::abs64(term);
        alu_req.b     = 32'(run_len);
      end
      lnfb_pkg::ST_B2_DIV: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = lnfb_pkg::OP_MUL;
        alu_req.a     = quot;
        alu_req.b     = inverse_std;
      end
      lnfb_pkg::ST_PUT: begin
        s_we    = (run_kind == lnfb_pkg::KIND_FWD);
        s_waddr = idx;
        s_wdata = sat_val;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lnfb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      epsilon <= cfg_data;
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      fwd_len       <= '0;
      overflow_flag <= 1'b0;
      inverse_std   <= '0;
    end else begin
      if (in_fire) begin
        if (has_room) begin
          element_count <= element_count + CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
        if (last && (action == lnfb_pkg::KIND_BWD) && (fwd_len == '0)) begin
          element_count <= '0;
          overflow_flag <= 1'b0;
        end
      end
      if ((state == lnfb_pkg::ST_SQRT_WAIT) && alu_rsp.done && (quot == '0)) begin
        inverse_std <= 32'h7FFF_FFFF;
      end
      if ((state == lnfb_pkg::ST_INV_WAIT) && alu_rsp.done) begin
        inverse_std <= inv_sat;
      end
      if ((state == lnfb_pkg::ST_EMIT) && out_fire && idx_last) begin
        element_count <= '0;
        overflow_flag <= 1'b0;
        if (run_kind == lnfb_pkg::KIND_FWD) begin
          fwd_len <= run_len;
        end
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      lnfb_pkg::ST_IDLE: begin
        if (in_fire && last) begin
          run_kind <= action;
          idx      <= '0;
          sum      <= '0;
          acc2     <= '0;
          if (action == lnfb_pkg::KIND_FWD) begin
            run_len <= has_room ? (element_count + CNT_W'(1)) : element_count;
          end else begin
            run_len <= fwd_len;
          end
        end
      end
      lnfb_pkg::ST_SUM_ACC: begin
        sum <= sum + {{32{s_rdata[31]}}, s_rdata};
        if (!idx_last) idx <= idx + ADDR_W'(1);
      end
      lnfb_pkg::ST_MEAN_WAIT: begin
        if (alu_rsp.done) begin
          mean <= mean_q;
          idx  <= '0;
          acc2 <= '0;
        end
      end
      lnfb_pkg::ST_VAR_WAIT: begin
        if (alu_rsp.done) begin
          acc2 <= acc2 + prod_sh[63:0];
          if (!idx_last) idx <= idx + ADDR_W'(1);
        end
      end
      lnfb_pkg::ST_SQRT_WAIT: begin
        if (alu_rsp.done) begin
          sd  <= quot[31:0];
          idx <= '0;
        end
      end
      lnfb_pkg::ST_X_GO: begin
        neg <= dev[32];
        quo <= (dev_mag == '0) ? 64'd0 : lnfb_pkg::MAG_CAP;
      end
      lnfb_pkg::ST_X_WAIT: begin
        if (alu_rsp.done) quo <= quot;
      end
      lnfb_pkg::ST_B1_GO: begin
        sum  <= sum + {{32{e_rdata[31]}}, e_rdata};
        pneg <= e_rdata[31] ^ s_rdata[31];
      end
      lnfb_pkg::ST_B1_WAIT: begin
        if (alu_rsp.done) begin
          acc2 <= acc2 + sp;
          idx  <= idx_last ? '0 : (idx + ADDR_W'(1));
        end
      end
      lnfb_pkg::ST_B2_GO: begin
        dy   <= e_rdata;
        pneg <= acc2[63] ^ s_rdata[31];
      end
      lnfb_pkg::ST_B2_WAIT: begin
        if (alu_rsp.done) neg <= term[63];
      end
      lnfb_pkg::ST_B2_SC: begin
        if (alu_rsp.done) quo <= prod_cap;
      end
      lnfb_pkg::ST_PUT: begin
        result_value <= sat_val;
        result_kind  <= run_kind;
        result_last  <= idx_last;
        truncated    <= overflow_flag;
      end
      lnfb_pkg::ST_EMIT: begin
        if (out_fire && !idx_last) idx <= idx + ADDR_W'(1);
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  `LNFB_ASSERT_IMP(one_side_open, in_ready, !out_valid, "input and output open together")
  `LNFB_ASSERT_IMP(count_in_range, 1'b1, element_count <= MAX_CNT, "element count past capacity")
  `LNFB_ASSERT_NXT(idle_after_final, out_valid && out_ready && result_last, in_ready,
                   "block not idle after the final result")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int NFEAT = 64;
  localparam int FRAC = 16;
  localparam int LIMIT = 3000000;
  localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;

  // One expected result item.
  typedef struct {
    logic [31:0] val;
    logic kind;
    logic fin;
    logic trunc;
  } norm_result_t;

  // Tracks the layer norm state and holds the results still owed by the block.
  class norm_scoreboard;
    int samples[NFEAT];
    int errors_in[NFEAT];
    int unsigned count;
    int unsigned flen;
    longint unsigned inv_root;
    bit ovf;
    longint unsigned eps;
    norm_result_t owed[$];
    int mismatches;

    function void clear();
      count = 0;
      flen = 0;
      inv_root = 0;
      ovf = 0;
      eps = 1;
      mismatches = 0;
      owed.delete();
    endfunction

    function void set_epsilon(logic [30:0] e);
      eps = e;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function int saturate(bit neg, longint unsigned m);
      if (neg) return m >= 64'h8000_0000 ? 32'h8000_0000 : -int'(m[31:0]);
      return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : int'(m[31:0]);
    endfunction

    // Bitwise integer square root.
    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Shifted product with its magnitude capped.
    function longint unsigned scaled_product(longint unsigned a, longint unsigned b);
      longint unsigned hi, lo, ph, pl, r;
      hi = a >> 32;
      lo = a & 64'hFFFF_FFFF;
      ph = hi * b;
      pl = lo * b;
      if (ph >= (64'd1 << (30 + FRAC))) return CAP;
      r = (ph << (32 - FRAC)) + (pl >> FRAC);
      return r > CAP ? CAP : r;
    endfunction

    function void add_owed(int v, logic kind, bit fin);
      norm_result_t e;
      e.val = v;
      e.kind = kind;
      e.fin = fin;
      e.trunc = ovf;
      owed.push_back(e);
    endfunction

    function void normalize_samples();
      int unsigned n;
      longint sum, mean, dev;
      longint unsigned vsum, var_sum, sd, d, xm, q;
      n = count;
      sum = 0;
      vsum = 0;
      for (int i = 0; i < n; i++) sum += longint'(samples[i]);
      mean = sum / longint'(n);
      for (int i = 0; i < n; i++) begin
        d = mag(longint'(samples[i]) - mean);
        vsum += (d * d) >> FRAC;
      end
      var_sum = vsum / longint'(n) + eps;
      if (var_sum > (64'd1 << (63 - FRAC)) - 1) var_sum = (64'd1 << (63 - FRAC)) - 1;
      sd = int_root(var_sum << FRAC);
      if (sd == 0) begin
        inv_root = 64'h7FFF_FFFF;
      end else begin
        q = (64'd1 << (2 * FRAC)) / sd;
        inv_root = q > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : q;
      end
      for (int i = 0; i < n; i++) begin
        dev = longint'(samples[i]) - mean;
        d = mag(dev);
        if (sd == 0) xm = (d == 0) ? 0 : CAP;
        else xm = (d << FRAC) / sd;
        samples[i] = saturate(dev < 0, xm);
        add_owed(samples[i], lnfb_pkg::KIND_FWD, i + 1 == n);
      end
      flen = n;
    endfunction

    function void backpropagate();
      longint sdy, sdx, dy, xh, sp, term, t;
      longint unsigned p;
      sdy = 0;
      sdx = 0;
      for (int i = 0; i < flen; i++) begin
        dy = errors_in[i];
        xh = samples[i];
        p = scaled_product(mag(dy), mag(xh));
        sdy += dy;
        sdx += ((dy < 0) != (xh < 0)) ? -longint'(p) : longint'(p);
      end
      for (int i = 0; i < flen; i++) begin
        dy = errors_in[i];
        xh = samples[i];
        p = scaled_product(mag(sdx), mag(xh));
        sp = ((sdx < 0) != (xh < 0)) ? -longint'(p) : longint'(p);
        term = longint'(flen) * dy - sdy - sp;
        t = term / longint'(flen);
        add_owed(saturate(t < 0, scaled_product(mag(t), inv_root)), lnfb_pkg::KIND_BWD,
                 i + 1 == flen);
      end
    endfunction

    // Called for every accepted input item.
    function void note_item(logic act, logic [31:0] v, logic fin);
      if (count < NFEAT) begin
        if (act == lnfb_pkg::KIND_BWD) errors_in[count] = v;
        else samples[count] = v;
        count++;
      end else begin
        ovf = 1;
      end
      if (fin) begin
        if (act == lnfb_pkg::KIND_BWD) backpropagate();
        else normalize_samples();
        count = 0;
        ovf = 0;
      end
    endfunction

    // Called for every accepted result item.
    task check_result(logic [31:0] v, logic kind, logic fin, logic trunc);
      norm_result_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h kind %b", v, kind));
      end else begin
        e = owed.pop_front();
        if (v !== e.val || kind !== e.kind || fin !== e.fin || trunc !== e.trunc)
          report_mismatch($sformatf("got %h/%b/%b/%b want %h/%b/%b/%b", v, kind, fin,
                                    trunc, e.val, e.kind, e.fin, e.trunc));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [lnfb_pkg::EPS_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic action = 0;
  logic signed [lnfb_pkg::DATA_W-1:0] value = '0;
  logic last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [lnfb_pkg::DATA_W-1:0] result_value;
  logic result_kind;
  logic result_last;
  logic truncated;

  norm_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  layer_norm_forward_backward_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .value(value), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .result_kind(result_kind),
    .result_last(result_last), .truncated(truncated)
  );

  always #5 clk = ~clk;

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(result_value, result_kind, result_last, truncated);
  end

  task send_item(logic act, logic [31:0] v, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    action = act;
    value = v;
    last = fin;
    do @(posedge clk); while (!in_ready);
    sb.note_item(act, v, fin);
    @(negedge clk);
    in_valid = 0;
  endtask

  task drain();
    while (sb.pending() != 0) @(negedge clk);
    // A run that ends with no result may still be busy.
    repeat (40) @(negedge clk);
  endtask

  task write_epsilon(logic [30:0] e);
    drain();
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = e;
    do @(posedge clk); while (!cfg_ready);
    sb.set_epsilon(e);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 8) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (sel == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  // One vector; the last item's action selects the pass.
  task send_run(logic act, int n, bit mixed);
    logic a;
    for (int i = 0; i < n; i++) begin
      a = (mixed && i + 1 < n && $urandom_range(0, 3) == 0) ? ~act : act;
      send_item(a, pick_value(), i + 1 == n);
    end
  endtask

  task random_phase(int items);
    int sent, n, sel;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) n = $urandom_range(1, 8);
      else if (sel < 96) n = $urandom_range(9, 64);
      else n = $urandom_range(65, 68);
      send_run(1'($urandom_range(0, 1)), n, $urandom_range(0, 4) == 0);
      sent += n;
    end
  endtask

  initial begin
    sb.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Backward before any forward gives no result but fills the error store.
    send_run(lnfb_pkg::KIND_BWD, 65, 0);
    // Full forward with one element dropped, then a full backward.
    send_run(lnfb_pkg::KIND_FWD, 65, 0);
    send_run(lnfb_pkg::KIND_BWD, 64, 0);
    // Extremes, a single sample and a constant vector.
    send_item(lnfb_pkg::KIND_FWD, 32'h7FFF_FFFF, 0);
    send_item(lnfb_pkg::KIND_FWD, 32'h8000_0000, 1);
    send_item(lnfb_pkg::KIND_BWD, 32'h8000_0000, 0);
    send_item(lnfb_pkg::KIND_BWD, 32'h7FFF_FFFF, 1);
    send_item(lnfb_pkg::KIND_FWD, 32'h0001_0000, 1);
    write_epsilon(31'd0);
    for (int i = 0; i < 4; i++) send_item(lnfb_pkg::KIND_FWD, 32'h0003_0000, i == 3);
    send_run(lnfb_pkg::KIND_BWD, 4, 1);
    send_item(lnfb_pkg::KIND_FWD, 32'hFFFF_0000, 1);

    // Traffic phases, each at a different epsilon.
    write_epsilon(31'h7FFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(28);
    write_epsilon(31'd1);
    send_idle_pct = 57;
    recv_stall_pct = 0;
    random_phase(28);
    write_epsilon(31'($urandom_range(0, 32'h0002_0000)));
    send_idle_pct = 0;
    recv_stall_pct = 57;
    random_phase(28);
    write_epsilon(31'($urandom()));
    send_idle_pct = 35;
    recv_stall_pct = 35;
    random_phase(28);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
